// ===== sv/fsp_pkg.sv =====
// Shared widths, opcodes and status codes of the fixed-slot pool allocator.
package fsp_pkg;

  localparam int OPCODE_W  = 3;
  localparam int SLOT_W    = 10;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 11;
  localparam int COUNT_RST = 1024;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam opcode_t OP_ALLOC      = 3'd0;
  localparam opcode_t OP_FREE       = 3'd1;
  localparam opcode_t OP_ITER_START = 3'd2;
  localparam opcode_t OP_ITER_NEXT  = 3'd3;
  localparam opcode_t OP_REBUILD    = 3'd4;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_BAD_FREE = 2'd2;
  localparam status_t ST_DONE     = 2'd3;

endpackage

// ===== sv/fsp_if.sv =====
// Valid/ready channel interfaces for operations, results and the slot count register.
interface fsp_op_if;
  logic             valid;
  logic             ready;
  fsp_pkg::opcode_t opcode;
  fsp_pkg::slot_t   slot;

  modport source (output valid, output opcode, output slot, input ready);
  modport sink   (input valid, input opcode, input slot, output ready);
endinterface

interface fsp_res_if;
  logic             valid;
  logic             ready;
  fsp_pkg::status_t status;
  fsp_pkg::slot_t   slot_out;

  modport source (output valid, output status, output slot_out, input ready);
  modport sink   (input valid, input status, input slot_out, output ready);
endinterface

interface fsp_cfg_if;
  logic            valid;
  logic            ready;
  fsp_pkg::count_t slot_count;

  modport source (output valid, output slot_count, input ready);
  modport sink   (input valid, input slot_count, output ready);
endinterface

// ===== sv/fsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fixed_slot_pool_allocator.sv =====
// Fixed-slot pool allocator: LIFO free list and used marks held in two RAMs.
//
// Allocate, free and unknown opcodes read the link or used-mark RAM while the
// operation is accepted and update it in the execute state. Iterate start and
// iterate next read used marks in the scan state, up to and including the used
// slot found or the last slot of the pool; the used-mark RAM delivers one mark per
// cycle. Iterate next goes straight to the execute state when the iteration is
// already finished. Rebuild rewrites every RAM entry, one per cycle.
// After reset a clearing pass over every RAM entry runs with op.ready low;
// slot count writes are taken at any time and apply at the next rebuild.
// A finished result waits in the output register while the next operation
// is accepted; the block holds its following result until res.ready.
module fixed_slot_pool_allocator #(
  parameter int MAX_SLOTS = 1024
) (
  input logic clk,
  input logic rst,
  fsp_cfg_if.sink   cfg,
  fsp_op_if.sink    op,
  fsp_res_if.source res
);

  localparam int IW    = $clog2(MAX_SLOTS);
  localparam int LW    = $clog2(MAX_SLOTS + 1);
  localparam int CW    = (LW > fsp_pkg::COUNT_W) ? LW : fsp_pkg::COUNT_W;
  localparam int RST_N = (MAX_SLOTS < fsp_pkg::COUNT_RST) ? MAX_SLOTS : fsp_pkg::COUNT_RST;

  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_SLOTS);
  localparam logic [LW-1:0] LAST_IDX  = LW'(MAX_SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state, state_next;

  fsp_pkg::count_t  slot_count;
  logic [LW-1:0]    n, n_next;
  logic [LW-1:0]    head, head_next;
  logic [LW-1:0]    cursor, cursor_next;
  logic [LW-1:0]    sweep_addr, sweep_addr_next;
  logic             sweep_reply, sweep_reply_next;
  logic [LW-1:0]    scan_addr, scan_addr_next;
  logic             chk_valid, chk_valid_next;
  logic [LW-1:0]    chk_addr, chk_addr_next;
  fsp_pkg::opcode_t op_code;
  fsp_pkg::slot_t   op_slot;

  logic             res_valid;
  fsp_pkg::status_t res_status;
  fsp_pkg::slot_t   res_slot;
  fsp_pkg::status_t hold_status;
  fsp_pkg::slot_t   hold_slot;

  logic             fin;
  fsp_pkg::status_t fin_status;
  fsp_pkg::slot_t   fin_slot;
  logic             out_ok;

  logic [CW-1:0]    cnt_ext;
  logic [LW-1:0]    n_clamp;
  logic [LW-1:0]    cur_inc;
  logic [LW-1:0]    sweep_inc;

  logic             link_we, used_we;
  logic [IW-1:0]    link_waddr, link_raddr, used_waddr, used_raddr;
  logic [LW-1:0]    link_wdata, link_rdata;
  logic             used_wdata, used_rdata;

  fsp_ram #(.WIDTH(LW), .DEPTH(MAX_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  fsp_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (used_raddr),
    .rdata (used_rdata)
  );

  assign out_ok    = !res_valid || res.ready;
  assign cur_inc   = cursor + LW'(1);
  assign sweep_inc = sweep_addr + LW'(1);

  always_comb begin
    cnt_ext = CW'(slot_count);
    if (cnt_ext == '0) begin
      n_clamp = LW'(1);
    end else if (cnt_ext > CW'(MAX_SLOTS)) begin
      n_clamp = LW'(MAX_SLOTS);
    end else begin
      n_clamp = LW'(cnt_ext);
    end
  end

  always_comb begin
    state_next       = state;
    n_next           = n;
    head_next        = head;
    cursor_next      = cursor;
    sweep_addr_next  = sweep_addr;
    sweep_reply_next = sweep_reply;
    scan_addr_next   = scan_addr;
    chk_valid_next   = 1'b0;
    chk_addr_next    = chk_addr;
    fin              = 1'b0;
    fin_status       = fsp_pkg::ST_OK;
    fin_slot         = '0;
    link_we          = 1'b0;
    link_waddr       = IW'(op_slot);
    link_wdata       = head;
    link_raddr       = IW'(head);
    used_we          = 1'b0;
    used_waddr       = IW'(op_slot);
    used_wdata       = 1'b0;
    used_raddr       = IW'(op.slot);

    unique case (state)
      S_IDLE: begin
        if (op.valid) begin
          case (op.opcode)
            fsp_pkg::OP_ITER_START: begin
              scan_addr_next = '0;
              state_next     = S_SCAN;
            end
            fsp_pkg::OP_ITER_NEXT: begin
              if (cursor >= n || cur_inc >= n) begin
                state_next = S_EXEC;
              end else begin
                scan_addr_next = cur_inc;
                state_next     = S_SCAN;
              end
            end
            fsp_pkg::OP_REBUILD: begin
              n_next           = n_clamp;
              sweep_addr_next  = '0;
              sweep_reply_next = 1'b1;
              state_next       = S_SWEEP;
            end
            default: begin
              state_next = S_EXEC;
            end
          endcase
        end
      end

      S_EXEC: begin
        fin = 1'b1;
        case (op_code)
          fsp_pkg::OP_ALLOC: begin
            if (head == NULL_LINK) begin
              fin_status = fsp_pkg::ST_EMPTY;
            end else begin
              fin_slot   = fsp_pkg::SLOT_W'(head);
              head_next  = link_rdata;
              used_we    = 1'b1;
              used_waddr = IW'(head);
              used_wdata = 1'b1;
            end
          end
          fsp_pkg::OP_FREE: begin
            if (CW'(op_slot) >= CW'(n) || !used_rdata) begin
              fin_status = fsp_pkg::ST_BAD_FREE;
            end else begin
              link_we    = 1'b1;
              used_we    = 1'b1;
              head_next  = LW'(op_slot);
            end
          end
          fsp_pkg::OP_ITER_NEXT: begin
            fin_status  = fsp_pkg::ST_DONE;
            cursor_next = n;
          end
          default: begin
            fin_status = fsp_pkg::ST_OK;
          end
        endcase
      end

      S_SCAN: begin
        used_raddr     = IW'(scan_addr);
        chk_valid_next = (scan_addr < n);
        chk_addr_next  = scan_addr;
        if (scan_addr < n) begin
          scan_addr_next = scan_addr + LW'(1);
        end
        if (chk_valid && used_rdata) begin
          fin         = 1'b1;
          fin_slot    = fsp_pkg::SLOT_W'(chk_addr);
          cursor_next = chk_addr;
        end else if (chk_valid && chk_addr == n - LW'(1)) begin
          fin         = 1'b1;
          fin_status  = fsp_pkg::ST_DONE;
          cursor_next = n;
        end
      end

      S_SWEEP: begin
        link_we    = 1'b1;
        link_waddr = IW'(sweep_addr);
        link_wdata = (sweep_inc < n) ? sweep_inc : NULL_LINK;
        used_we    = 1'b1;
        used_waddr = IW'(sweep_addr);
        used_wdata = 1'b0;
        sweep_addr_next = sweep_inc;
        if (sweep_addr == LAST_IDX) begin
          head_next        = '0;
          cursor_next      = n;
          sweep_reply_next = 1'b0;
          fin              = sweep_reply;
          state_next       = S_IDLE;
        end
      end

      S_HOLD: begin
        if (out_ok) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = out_ok ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      slot_count  <= fsp_pkg::COUNT_W'(fsp_pkg::COUNT_RST);
      n           <= LW'(RST_N);
      head        <= '0;
      cursor      <= LW'(RST_N);
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      scan_addr   <= '0;
      chk_valid   <= 1'b0;
      chk_addr    <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      n           <= n_next;
      head        <= head_next;
      cursor      <= cursor_next;
      sweep_addr  <= sweep_addr_next;
      sweep_reply <= sweep_reply_next;
      scan_addr   <= scan_addr_next;
      chk_valid   <= chk_valid_next;
      chk_addr    <= chk_addr_next;
      if (cfg.valid) begin
        slot_count <= cfg.slot_count;
      end
      if (fin && out_ok) begin
        res_valid <= 1'b1;
      end else if (state == S_HOLD && out_ok) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && op.valid) begin
      op_code <= op.opcode;
      op_slot <= op.slot;
    end
    if (fin && out_ok) begin
      res_status <= fin_status;
      res_slot   <= fin_slot;
    end else if (state == S_HOLD && out_ok) begin
      res_status <= hold_status;
      res_slot   <= hold_slot;
    end
    if (fin && !out_ok) begin
      hold_status <= fin_status;
      hold_slot   <= fin_slot;
    end
  end

  assign op.ready     = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign res.valid    = res_valid;
  assign res.status   = res_status;
  assign res.slot_out = res_slot;

endmodule

// ===== sv/fsp_checker.sv =====
// Port-level assertions for the fixed-slot pool allocator and their bind.
module fsp_checker (
  input logic             clk,
  input logic             rst,
  input logic             op_valid,
  input logic             op_ready,
  input logic             res_valid,
  input logic             res_ready,
  input fsp_pkg::status_t res_status,
  input fsp_pkg::slot_t   res_slot_out
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_slot_out))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> !op_ready)
    else $error("operation beat accepted while previous one in progress");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !op_ready)
    else $error("operation beat offered before clearing pass finished");

  a_slot_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_slot_out != '0 |-> res_status == fsp_pkg::ST_OK)
    else $error("nonzero slot with failing status");

endmodule

bind fixed_slot_pool_allocator fsp_checker u_fsp_checker (
  .clk          (clk),
  .rst          (rst),
  .op_valid     (op.valid),
  .op_ready     (op.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_status   (res.status),
  .res_slot_out (res.slot_out)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the fixed-slot pool allocator: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

  localparam int               MAX_SLOTS   = 1024;
  localparam fsp_pkg::count_t  NIL         = fsp_pkg::count_t'(MAX_SLOTS);
  localparam fsp_pkg::opcode_t OP_RSVD_LO  = 3'd5;
  localparam fsp_pkg::opcode_t OP_RSVD_HI  = 3'd7;
  localparam int               QUIET_LIMIT = 8000;
  localparam int               HOLD_CYCLES = 300;
  localparam int               SETTLE      = 64;
  localparam int               NPHASE      = 12;
  localparam int               NDIR        = 26;

  typedef struct packed {
    fsp_pkg::status_t st;
    fsp_pkg::slot_t   slot;
  } pool_result_t;

  typedef struct packed {
    logic             cfg_row;
    fsp_pkg::opcode_t oc;
    fsp_pkg::slot_t   slot;
    fsp_pkg::count_t  cnt;
    logic             typed;
    fsp_pkg::status_t st;
    fsp_pkg::slot_t   so;
  } dir_row_t;

  localparam dir_row_t DIRECTED [NDIR] = '{
    '{1'b0, fsp_pkg::OP_ITER_NEXT,  10'd0,    11'd0, 1'b1, fsp_pkg::ST_DONE,     10'd0},
    '{1'b0, fsp_pkg::OP_ITER_START, 10'd0,    11'd0, 1'b1, fsp_pkg::ST_DONE,     10'd0},
    '{1'b0, fsp_pkg::OP_FREE,       10'd5,    11'd0, 1'b1, fsp_pkg::ST_BAD_FREE, 10'd0},
    '{1'b0, fsp_pkg::OP_ALLOC,      10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_ALLOC,      10'd1023, 11'd0, 1'b1, fsp_pkg::ST_OK,       10'd1},
    '{1'b0, fsp_pkg::OP_ALLOC,      10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd2},
    '{1'b0, fsp_pkg::OP_FREE,       10'd1,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_ALLOC,      10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd1},
    '{1'b0, fsp_pkg::OP_ITER_START, 10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_ITER_NEXT,  10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd1},
    '{1'b0, fsp_pkg::OP_FREE,       10'd1,    11'd0, 1'b0, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_ITER_NEXT,  10'd0,    11'd0, 1'b0, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_ITER_NEXT,  10'd0,    11'd0, 1'b1, fsp_pkg::ST_DONE,     10'd0},
    '{1'b0, fsp_pkg::OP_ITER_NEXT,  10'd0,    11'd0, 1'b1, fsp_pkg::ST_DONE,     10'd0},
    '{1'b0, OP_RSVD_LO,             10'd1023, 11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, OP_RSVD_HI,             10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_FREE,       10'd1023, 11'd0, 1'b1, fsp_pkg::ST_BAD_FREE, 10'd0},
    '{1'b0, fsp_pkg::OP_REBUILD,    10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0},
    '{1'b1, fsp_pkg::OP_ALLOC,      10'd0,    11'd0, 1'b0, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_REBUILD,    10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_ALLOC,      10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_ALLOC,      10'd0,    11'd0, 1'b1, fsp_pkg::ST_EMPTY,    10'd0},
    '{1'b0, fsp_pkg::OP_FREE,       10'd1,    11'd0, 1'b1, fsp_pkg::ST_BAD_FREE, 10'd0},
    '{1'b0, fsp_pkg::OP_ITER_START, 10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0},
    '{1'b0, fsp_pkg::OP_ITER_NEXT,  10'd0,    11'd0, 1'b1, fsp_pkg::ST_DONE,     10'd0},
    '{1'b0, fsp_pkg::OP_FREE,       10'd0,    11'd0, 1'b1, fsp_pkg::ST_OK,       10'd0}
  };

  logic clk;
  logic rst;

  fsp_op_if  op_bus ();
  fsp_res_if res_bus ();
  fsp_cfg_if cfg_bus ();

  fixed_slot_pool_allocator #(
    .MAX_SLOTS (MAX_SLOTS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .op  (op_bus),
    .res (res_bus)
  );

  // pool predictor state
  fsp_pkg::count_t free_next [MAX_SLOTS];
  bit              in_use    [MAX_SLOTS];
  fsp_pkg::count_t free_head;
  fsp_pkg::count_t scan_pos;
  fsp_pkg::count_t live_count;
  fsp_pkg::count_t count_reg;

  pool_result_t pending_results [$];

  int  errors;
  int  ops_sent;
  int  results_seen;
  int  phases_run;
  int  status_hits [4];
  int  burst_left;
  int  quiet;
  bit  long_hold;

  function automatic void pool_rebuild();
    live_count = (count_reg == 0) ? fsp_pkg::count_t'(1) :
                 (count_reg > MAX_SLOTS) ? NIL : count_reg;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free_next[i] = (i + 1 < live_count) ? fsp_pkg::count_t'(i + 1) : NIL;
      in_use[i]    = 1'b0;
    end
    free_head = '0;
    scan_pos  = live_count;
  endfunction

  function automatic void pool_scan(input int from, output fsp_pkg::status_t st,
                                    output fsp_pkg::slot_t so);
    st       = fsp_pkg::ST_DONE;
    so       = '0;
    scan_pos = live_count;
    for (int i = from; i < live_count; i++) begin
      if (in_use[i]) begin
        scan_pos = fsp_pkg::count_t'(i);
        so       = fsp_pkg::slot_t'(i);
        st       = fsp_pkg::ST_OK;
        break;
      end
    end
  endfunction

  function automatic void pool_apply(input fsp_pkg::opcode_t oc, input fsp_pkg::slot_t s,
                                     output fsp_pkg::status_t st,
                                     output fsp_pkg::slot_t so);
    st = fsp_pkg::ST_OK;
    so = '0;
    case (oc)
      fsp_pkg::OP_ALLOC: begin
        if (free_head >= NIL) begin
          st = fsp_pkg::ST_EMPTY;
        end else begin
          so         = fsp_pkg::slot_t'(free_head);
          free_head  = free_next[so];
          in_use[so] = 1'b1;
        end
      end
      fsp_pkg::OP_FREE: begin
        if (s >= live_count || !in_use[s]) begin
          st = fsp_pkg::ST_BAD_FREE;
        end else begin
          free_next[s] = free_head;
          free_head    = fsp_pkg::count_t'(s);
          in_use[s]    = 1'b0;
        end
      end
      fsp_pkg::OP_ITER_START: pool_scan(0, st, so);
      fsp_pkg::OP_ITER_NEXT: begin
        if (scan_pos >= live_count) begin
          scan_pos = live_count;
          st       = fsp_pkg::ST_DONE;
        end else begin
          pool_scan(scan_pos + 1, st, so);
        end
      end
      fsp_pkg::OP_REBUILD: pool_rebuild();
      default: ;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_op(input fsp_pkg::opcode_t oc, input fsp_pkg::slot_t s,
                         input bit typed, input fsp_pkg::status_t t_st,
                         input fsp_pkg::slot_t t_so);
    int               gap;
    fsp_pkg::status_t st;
    fsp_pkg::slot_t   so;
    pool_result_t     r;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    repeat (gap) begin
      op_bus.valid <= 1'b0;
      @(negedge clk);
    end
    op_bus.valid  <= 1'b1;
    op_bus.opcode <= oc;
    op_bus.slot   <= s;
    do @(posedge clk); while (!op_bus.ready);
    pool_apply(oc, s, st, so);
    r.st   = typed ? t_st : st;
    r.slot = typed ? t_so : so;
    pending_results.push_back(r);
    ops_sent++;
  endtask

  task automatic drain_ops();
    @(negedge clk);
    op_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_slot_count(input fsp_pkg::count_t v);
    drain_ops();
    @(negedge clk);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.slot_count <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    count_reg = v;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // result receiver: random stall stretches plus one long hold-off on request
  initial begin
    int mode_left;
    int stall_pct;
    bit held_off;
    mode_left = 0;
    stall_pct = 0;
    held_off  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !held_off) begin
        held_off = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    pool_result_t e;
    if (!rst && res_bus.valid && res_bus.ready) begin
      results_seen++;
      status_hits[res_bus.status]++;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d slot_out %0d",
               res_bus.status, res_bus.slot_out);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (res_bus.status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, res_bus.status);
          errors++;
        end
        if (res_bus.slot_out !== e.slot) begin
          $error("slot_out: expected %0d, got %0d", e.slot, res_bus.slot_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("[fixed_slot_pool_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    fsp_pkg::count_t  cnt;
    fsp_pkg::opcode_t oc;
    fsp_pkg::slot_t   s;
    int               alloc_pct;
    int               n_items;
    int               r;
    int               start;
    int               idx;
    bit               found;
    rst                = 1'b1;
    op_bus.valid       = 1'b0;
    op_bus.opcode      = fsp_pkg::OP_ALLOC;
    op_bus.slot        = '0;
    res_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.slot_count = '0;
    errors             = 0;
    ops_sent           = 0;
    results_seen       = 0;
    phases_run         = 0;
    burst_left         = 0;
    quiet              = 0;
    long_hold          = 1'b0;
    status_hits        = '{default: 0};
    count_reg          = fsp_pkg::count_t'(fsp_pkg::COUNT_RST);
    pool_rebuild();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg_row) begin
        write_slot_count(DIRECTED[i].cnt);
      end else begin
        send_op(DIRECTED[i].oc, DIRECTED[i].slot, DIRECTED[i].typed,
                DIRECTED[i].st, DIRECTED[i].so);
      end
    end

    for (int ph = 0; ph < NPHASE; ph++) begin
      case (ph)
        0: cnt = 11'd2047;
        1: cnt = 11'd1;
        2: cnt = 11'd2;
        3: cnt = 11'd16;
        4: cnt = 11'd0;
        5: cnt = 11'd1024;
        6: cnt = 11'd5;
        7: cnt = fsp_pkg::count_t'($urandom_range(0, 2047));
        default: cnt = fsp_pkg::count_t'($urandom_range(2, 40));
      endcase
      write_slot_count(cnt);
      send_op(fsp_pkg::OP_REBUILD, fsp_pkg::slot_t'($urandom_range(0, 1023)), 1'b0,
              fsp_pkg::ST_OK, '0);
      phases_run++;
      alloc_pct = $urandom_range(20, 50);
      n_items   = (live_count >= 256) ? 15 : 42;
      for (int k = 0; k < n_items; k++) begin
        if (ph == 3 && k == 10) long_hold = 1'b1;
        if (ph == 6 && k == 20) drain_ops();
        s = fsp_pkg::slot_t'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
          oc = fsp_pkg::OP_ALLOC;
        end else if (r < alloc_pct + 30) begin
          oc = fsp_pkg::OP_FREE;
          case ($urandom_range(0, 5))
            0: ;
            1: s = fsp_pkg::slot_t'(live_count - $urandom_range(0, 1));
            default: begin
              // free a live slot when one exists
              found = 1'b0;
              start = $urandom_range(0, live_count - 1);
              for (int j = 0; j < live_count && !found; j++) begin
                idx = (start + j) % live_count;
                if (in_use[idx]) begin
                  s     = fsp_pkg::slot_t'(idx);
                  found = 1'b1;
                end
              end
            end
          endcase
        end else if (r < alloc_pct + 38) begin
          oc = fsp_pkg::OP_ITER_START;
        end else if (r < alloc_pct + 62) begin
          oc = fsp_pkg::OP_ITER_NEXT;
        end else if (r < alloc_pct + 65) begin
          oc = fsp_pkg::OP_REBUILD;
        end else if (r < alloc_pct + 68) begin
          oc = fsp_pkg::opcode_t'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        end else begin
          oc = fsp_pkg::OP_ALLOC;
        end
        send_op(oc, s, 1'b0, fsp_pkg::ST_OK, '0);
      end
    end

    drain_ops();
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("%0d operations over %0d pool sizes, %0d results compared",
             ops_sent, phases_run, results_seen);
    $display("empty pool %0d, rejected free %0d, scan exhausted %0d; hold-off and drain done",
             status_hits[fsp_pkg::ST_EMPTY], status_hits[fsp_pkg::ST_BAD_FREE],
             status_hits[fsp_pkg::ST_DONE]);
    if (errors == 0) begin
      $display("[fixed_slot_pool_allocator] OK");
    end else begin
      $display("[fixed_slot_pool_allocator] ERROR");
    end
    $finish;
  end

endmodule
